@@ src/coding_cookie_detect_macros.svh @@
// assertion macros used by coding_cookie_detect.sv
`ifndef CODING_COOKIE_DETECT_MACROS_SVH
`define CODING_COOKIE_DETECT_MACROS_SVH

// same-cycle implication, checked on clk, quiet while arst_n is low
`define CCD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, checked on clk, quiet while arst_n is low
`define CCD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ src/ccd_pkg.sv @@
`default_nettype none

package ccd_pkg;

	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_LF    = 8'h0A;
	localparam logic [7:0] CHR_TAB   = 8'h09;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_COLON = 8'h3A;
	localparam logic [7:0] CHR_EQUAL = 8'h3D;
	localparam logic [7:0] CHR_DQUOTE = 8'h22;
	localparam logic [7:0] CHR_SQUOTE = 8'h27;
	localparam logic [7:0] CHR_LOW_C = 8'h63;

	localparam logic [2:0] KEYWORD_LEN = 3'd6;
	localparam logic [2:0] TARGET_LEN  = 3'd5;

	typedef enum logic [2:0] {
		PH_SEARCH    = 3'd0,
		PH_SEPARATOR = 3'd1,
		PH_QUOTE     = 3'd2,
		PH_SPACES    = 3'd3,
		PH_TOKEN     = 3'd4,
		PH_SKIP_LINE = 3'd5
	} phase_t;

	typedef struct packed {
		logic       line_number;
		logic [2:0] keyword_pos;
		phase_t     phase;
		logic [2:0] token_len;
		logic       token_match;
		logic       pending_cr;
		logic       verdict_given;
	} scan_state_t;

	typedef struct packed {
		logic       is_utf8;
		logic [1:0] cookie_line;
	} verdict_t;

	localparam scan_state_t SCAN_RESET = '{
		line_number:   1'b0,
		keyword_pos:   3'd0,
		phase:         PH_SEARCH,
		token_len:     3'd0,
		token_match:   1'b1,
		pending_cr:    1'b0,
		verdict_given: 1'b0
	};

	// letters of "coding"
	function automatic logic [7:0] keyword_char(input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0: c = 8'h63;
			3'd1: c = 8'h6F;
			3'd2: c = 8'h64;
			3'd3: c = 8'h69;
			3'd4: c = 8'h6E;
			3'd5: c = 8'h67;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// letters of "utf-8"
	function automatic logic [7:0] target_char(input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0: c = 8'h75;
			3'd1: c = 8'h74;
			3'd2: c = 8'h66;
			3'd3: c = 8'h2D;
			3'd4: c = 8'h38;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_token_char(input logic [7:0] b);
		return (b == 8'h5F) || (b == 8'h2D) || (b == 8'h2E) ||
			(b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
			(b >= 8'h30 && b <= 8'h39);
	endfunction

endpackage

`default_nettype wire

@@ src/coding_cookie_detect.sv @@
`default_nettype none

// channel  dir  tdata                                      tlast      tuser
// s_*      in   [7:0] byte_value                           last_byte  -
// m_*      out  [0] is_utf8, [2:1] cookie_line, [7:3] 0    -          -
//
// one word per cycle unless m_* stalls; a verdict reaches m_* via the byte and result registers
// the scan state, and a full byte register, advance only when the result register can take
//   a new word, so the next-state logic of one byte sets the cycle
// at most one result word per buffer; bytes after the verdict give nothing until last_byte
// arst_n clears both valid flags and the scan state at once
// a stall on m_tready holds the result; the byte register holds one more word, then s_tready drops
module coding_cookie_detect (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] byte_value
	input  wire logic       s_tlast,   // last_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata    // [0] is_utf8, [2:1] cookie_line, [7:3] zero
);
	import ccd_pkg::*;

	`include "coding_cookie_detect_macros.svh"

	// byte register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// scan state across bytes
	scan_state_t state_q;
	scan_state_t state_nxt;

	// result register
	logic        out_valid_q;
	verdict_t    out_q;

	logic        res_valid;
	verdict_t    res;
	logic        out_free;
	logic        advance;

	ccd_scan u_scan (
		.cur        (state_q),
		.byte_value (byte_s1),
		.last_byte  (last_s1),
		.nxt        (state_nxt),
		.res_valid  (res_valid),
		.res        (res)
	);

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || advance;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_q.cookie_line, out_q.is_utf8};

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= SCAN_RESET;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				state_q <= state_nxt;
			if (out_free)
				out_valid_q <= advance && res_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (advance && res_valid)
			out_q <= res;
	end

	`CCD_ASSERT_NOW(a_utf8_has_line, m_tvalid && out_q.is_utf8, out_q.cookie_line != 2'd0)
	`CCD_ASSERT_NOW(a_no_cookie_no_line, m_tvalid && !out_q.is_utf8, out_q.cookie_line == 2'd0)
	`CCD_ASSERT_NEXT(a_last_rearms, advance && last_s1, state_q == SCAN_RESET)
	`CCD_ASSERT_NOW(a_last_gives_verdict, advance && last_s1 && !state_q.verdict_given, res_valid)
	`CCD_ASSERT_NOW(a_silent_after_verdict, advance && state_q.verdict_given, !res_valid)

endmodule

`default_nettype wire

@@ src/ccd_scan.sv @@
`default_nettype none

// next-state and verdict logic for one byte
module ccd_scan (
	input  wire ccd_pkg::scan_state_t cur,
	input  wire logic [7:0]           byte_value,
	input  wire logic                 last_byte,
	output ccd_pkg::scan_state_t      nxt,
	output logic                      res_valid,
	output ccd_pkg::verdict_t         res
);
	import ccd_pkg::*;

	logic       term;
	logic       hit;
	logic       cont;
	logic [7:0] lc;

	always_comb begin
		nxt       = cur;
		res_valid = 1'b0;
		res       = '0;
		term      = (byte_value == CHR_CR) || (byte_value == CHR_LF);
		hit       = 1'b0;
		cont      = 1'b0;
		lc        = (byte_value >= 8'h41 && byte_value <= 8'h5A) ?
			byte_value + 8'h20 : byte_value;

		if (!cur.verdict_given) begin
			if (cur.pending_cr && byte_value == CHR_LF) begin
				nxt.pending_cr = 1'b0;
			end else begin
				nxt.pending_cr = 1'b0;

				// keyword search and separator
				if (cur.phase == PH_SEARCH) begin
					if (cur.keyword_pos < KEYWORD_LEN &&
						byte_value == keyword_char(cur.keyword_pos)) begin
						nxt.keyword_pos = cur.keyword_pos + 3'd1;
						if (cur.keyword_pos + 3'd1 == KEYWORD_LEN)
							nxt.phase = PH_SEPARATOR;
					end else begin
						nxt.keyword_pos = (byte_value == CHR_LOW_C) ? 3'd1 : 3'd0;
					end
				end else if (cur.phase == PH_SEPARATOR) begin
					nxt.phase = (byte_value == CHR_COLON || byte_value == CHR_EQUAL) ?
						PH_QUOTE : PH_SKIP_LINE;
				end

				// quote, spaces and token fall through on the same byte
				cont = (cur.phase == PH_QUOTE) || (cur.phase == PH_SPACES) ||
					(cur.phase == PH_TOKEN);
				if (cur.phase == PH_QUOTE) begin
					nxt.phase = PH_SPACES;
					if (byte_value == CHR_DQUOTE || byte_value == CHR_SQUOTE)
						cont = 1'b0;
				end
				if (cont && nxt.phase == PH_SPACES) begin
					if (byte_value == CHR_SPACE || byte_value == CHR_TAB)
						cont = 1'b0;
					else
						nxt.phase = PH_TOKEN;
				end
				if (cont && nxt.phase == PH_TOKEN) begin
					if (is_token_char(byte_value)) begin
						if (cur.token_len < TARGET_LEN) begin
							if (lc != target_char(cur.token_len))
								nxt.token_match = 1'b0;
							nxt.token_len = cur.token_len + 3'd1;
						end else begin
							nxt.token_match = 1'b0;
						end
					end else if (cur.token_match && cur.token_len == TARGET_LEN) begin
						hit = 1'b1;
					end else begin
						nxt.phase = PH_SKIP_LINE;
					end
				end

				if (hit) begin
					res_valid         = 1'b1;
					res.is_utf8       = 1'b1;
					res.cookie_line   = {1'b0, cur.line_number} + 2'd1;
					nxt.verdict_given = 1'b1;
				end else if (term) begin
					if (cur.line_number) begin
						res_valid         = 1'b1;
						nxt.verdict_given = 1'b1;
					end else begin
						nxt.line_number = 1'b1;
						nxt.keyword_pos = 3'd0;
						nxt.phase       = PH_SEARCH;
						nxt.token_len   = 3'd0;
						nxt.token_match = 1'b1;
						nxt.pending_cr  = (byte_value == CHR_CR);
					end
				end
			end

			// end of buffer without a verdict: an open utf-8 token still counts
			if (!nxt.verdict_given && last_byte) begin
				res_valid = 1'b1;
				if (nxt.phase == PH_TOKEN && nxt.token_match && nxt.token_len == TARGET_LEN) begin
					res.is_utf8     = 1'b1;
					res.cookie_line = {1'b0, nxt.line_number} + 2'd1;
				end
				nxt.verdict_given = 1'b1;
			end
		end

		if (last_byte)
			nxt = SCAN_RESET;
	end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
module tb;
	import ccd_pkg::*;

	// one byte of a buffer as it waits in the send queue
	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} buffer_byte_t;

	// scanner state kept by the prediction side
	typedef struct {
		bit          on_line2;
		int unsigned kw_pos;
		phase_t      ph;
		int unsigned tok_len;
		bit          tok_ok;
		bit          cr_open;
		bit          decided;
	} scan_model_t;

	localparam logic [47:0] KEYWORD_TXT = "coding";
	localparam logic [39:0] TARGET_TXT  = "utf-8";

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;

	buffer_byte_t bytes_to_send[$];
	verdict_t     verdicts_due[$];
	logic [7:0]   frame_bytes[$];
	scan_model_t  scan;
	int unsigned  words_in = 0;
	int unsigned  errors = 0;
	logic [1:0]   idle_mode = 2'd0;
	bit           drain_hold = 1'b0;

	coding_cookie_detect i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// verdict prediction
	// ---------------------------------------------------------------

	function automatic void clear_line();
		scan.kw_pos  = 0;
		scan.ph      = PH_SEARCH;
		scan.tok_len = 0;
		scan.tok_ok  = 1'b1;
	endfunction

	function automatic bit is_name_char(input logic [7:0] b);
		return b == "_" || b == "-" || b == "." || (b >= "a" && b <= "z") ||
			(b >= "A" && b <= "Z") || (b >= "0" && b <= "9");
	endfunction

	// one byte of the current line; returns 1 when a utf-8 token just closed
	function automatic bit feed_line(input logic [7:0] b);
		logic [7:0] lc;
		if (scan.ph == PH_SEARCH) begin
			if (scan.kw_pos < KEYWORD_LEN && b == KEYWORD_TXT[8*(5-scan.kw_pos) +: 8]) begin
				scan.kw_pos++;
				if (scan.kw_pos == KEYWORD_LEN)
					scan.ph = PH_SEPARATOR;
			end else begin
				// a 'c' may start a fresh match
				scan.kw_pos = (b == CHR_LOW_C) ? 1 : 0;
			end
			return 1'b0;
		end
		if (scan.ph == PH_SEPARATOR) begin
			scan.ph = (b == CHR_COLON || b == CHR_EQUAL) ? PH_QUOTE : PH_SKIP_LINE;
			return 1'b0;
		end
		if (scan.ph == PH_QUOTE) begin
			scan.ph = PH_SPACES;
			if (b == CHR_DQUOTE || b == CHR_SQUOTE)
				return 1'b0;
		end
		if (scan.ph == PH_SPACES) begin
			if (b == CHR_SPACE || b == CHR_TAB)
				return 1'b0;
			scan.ph = PH_TOKEN;
		end
		if (scan.ph == PH_TOKEN) begin
			if (is_name_char(b)) begin
				if (scan.tok_len < TARGET_LEN) begin
					lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
					if (lc != TARGET_TXT[8*(4-scan.tok_len) +: 8])
						scan.tok_ok = 1'b0;
					scan.tok_len++;
				end else begin
					// too long to be utf-8
					scan.tok_ok = 1'b0;
				end
				return 1'b0;
			end
			if (scan.tok_ok && scan.tok_len == TARGET_LEN)
				return 1'b1;
			scan.ph = PH_SKIP_LINE;
		end
		return 1'b0;
	endfunction

	// advance the model by one accepted word, queue the verdict it gives
	function automatic void scan_word(input logic [7:0] b, input logic last);
		bit       term;
		bit       give;
		bit       found;
		verdict_t v;
		give = 1'b0;
		v = '0;
		if (!scan.decided) begin
			if (scan.cr_open && b == CHR_LF) begin
				// lf of a cr lf pair, already counted
				scan.cr_open = 1'b0;
			end else begin
				term = (b == CHR_CR || b == CHR_LF);
				scan.cr_open = 1'b0;
				if (feed_line(b)) begin
					v.is_utf8 = 1'b1;
					v.cookie_line = scan.on_line2 ? 2'd2 : 2'd1;
					give = 1'b1;
				end else if (term) begin
					if (scan.on_line2) begin
						give = 1'b1;
					end else begin
						scan.on_line2 = 1'b1;
						clear_line();
						scan.cr_open = (b == CHR_CR);
					end
				end
			end
			if (give)
				scan.decided = 1'b1;
			if (!scan.decided && last) begin
				// a utf-8 token may still be open on the final byte
				found = scan.ph == PH_TOKEN && scan.tok_ok && scan.tok_len == TARGET_LEN;
				v.is_utf8 = found;
				v.cookie_line = found ? (scan.on_line2 ? 2'd2 : 2'd1) : 2'd0;
				give = 1'b1;
				scan.decided = 1'b1;
			end
		end
		if (give)
			verdicts_due.push_back(v);
		if (last) begin
			scan.on_line2 = 1'b0;
			clear_line();
			scan.cr_open = 1'b0;
			scan.decided = 1'b0;
		end
	endfunction

	// ---------------------------------------------------------------
	// buffer generation
	// ---------------------------------------------------------------

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			frame_bytes.push_back(s[i]);
	endfunction

	function automatic void add_from(input string palette, input int unsigned n);
		for (int i = 0; i < n; i++)
			frame_bytes.push_back(palette[$urandom_range(0, palette.len() - 1)]);
	endfunction

	// move the built buffer to the send queue, last byte flagged
	function automatic void flush_frame();
		buffer_byte_t w;
		if (frame_bytes.size() == 0)
			frame_bytes.push_back(8'($urandom_range(0, 255)));
		foreach (frame_bytes[i]) begin
			w.value = frame_bytes[i];
			w.last  = (i == frame_bytes.size() - 1);
			bytes_to_send.push_back(w);
		end
		frame_bytes.delete();
	endfunction

	function automatic void add_token();
		string      t;
		string      alt;
		int unsigned pick;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		t = "utf-8";
		alt = "uTf8-_.xA9";
		if (pick < 85) begin
			for (int i = 0; i < 5; i++) begin
				c = t[i];
				// random letter case
				if (c >= "a" && c <= "z" && $urandom_range(0, 1))
					c = c - 8'd32;
				if (pick >= 70 && i == $urandom_range(0, 4) && $urandom_range(0, 1))
					c = alt[$urandom_range(0, 9)];
				frame_bytes.push_back(c);
				// cut short now and then
				if (pick >= 70 && i < 4 && $urandom_range(0, 5) == 0)
					break;
			end
			if (pick >= 55 && pick < 70)
				add_from("_-.a9Z", $urandom_range(1, 3));
		end else if (pick < 93) begin
			add_from("latin-1_.Zq09", $urandom_range(1, 8));
		end
		// otherwise the token stays empty
	endfunction

	function automatic void add_line();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			add_from("# -*cCodinx:=\t", $urandom_range(0, 4));
			if ($urandom_range(0, 9) == 0)
				add_from("codingC", 6);
			else
				add_text("coding");
			case ($urandom_range(0, 19))
				0, 1: frame_bytes.push_back(8'($urandom_range(0, 255)));
				default: frame_bytes.push_back($urandom_range(0, 1) ? CHR_COLON : CHR_EQUAL);
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2: frame_bytes.push_back(CHR_DQUOTE);
				3, 4: frame_bytes.push_back(CHR_SQUOTE);
				default: ;
			endcase
			add_from(" \t", $urandom_range(0, 3));
			add_token();
			add_from("-* x\"", $urandom_range(0, 3));
		end else if (pick < 85) begin
			add_from("abc xyz#!cod\t", $urandom_range(0, 8));
		end else begin
			for (int i = $urandom_range(1, 6); i > 0; i--)
				frame_bytes.push_back(8'($urandom_range(0, 255)));
		end
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6: frame_bytes.push_back(CHR_LF);
			7, 8, 9, 10, 11: frame_bytes.push_back(CHR_CR);
			12, 13, 14, 15, 16: add_text("\r\n");
			default: ;
		endcase
	endfunction

	function automatic void build_random_frame();
		int unsigned n;
		for (int i = $urandom_range(1, 3); i > 0; i--)
			add_line();
		// sometimes end the buffer in mid line
		if (frame_bytes.size() > 1 && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, frame_bytes.size());
			frame_bytes = frame_bytes[0:n-1];
		end
		flush_frame();
	endfunction

	// ---------------------------------------------------------------
	// driver: one word in flight on s_*, refilled from the send queue
	// ---------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		logic         nxt_valid;
		logic [1:0]   cur_mode;
		bit           gap;
		buffer_byte_t w;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'h00;
			s_tlast  <= 1'b0;
		end else begin
			nxt_valid = s_tvalid;
			if (s_tvalid && s_tready) begin
				scan_word(s_tdata, s_tlast);
				words_in++;
				nxt_valid = 1'b0;
			end
			// idling pattern steps every 160 words; each step first drains the block
			cur_mode = 2'((words_in / 160) % 4);
			if (cur_mode != idle_mode) begin
				idle_mode <= cur_mode;
				drain_hold = 1'b1;
			end
			gap = (cur_mode == 2'd1 && $urandom_range(0, 99) < 52) ||
				(cur_mode == 2'd3 && $urandom_range(0, 99) < 12);
			if (!nxt_valid) begin
				if (drain_hold && verdicts_due.size() == 0)
					drain_hold = 1'b0;
				if (!drain_hold && !gap && bytes_to_send.size() > 0) begin
					w = bytes_to_send.pop_front();
					s_tdata  <= w.value;
					s_tlast  <= w.last;
					nxt_valid = 1'b1;
				end
			end
			s_tvalid <= nxt_valid;
		end
	end

	// ---------------------------------------------------------------
	// monitor: random back-pressure and verdict check
	// ---------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		bit       stall;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdicts_due.size() == 0) begin
					$display("%0t: verdict word %h with none expected", $time, m_tdata);
					errors++;
				end else begin
					want = verdicts_due.pop_front();
					if (m_tdata[0] !== want.is_utf8) begin
						$display("%0t: is_utf8 expected %0d got %0d",
							$time, want.is_utf8, m_tdata[0]);
						errors++;
					end
					if (m_tdata[2:1] !== want.cookie_line) begin
						$display("%0t: cookie_line expected %0d got %0d",
							$time, want.cookie_line, m_tdata[2:1]);
						errors++;
					end
					if (m_tdata[7:3] !== 5'd0) begin
						$display("%0t: pad bits expected 0 got %h", $time, m_tdata[7:3]);
						errors++;
					end
				end
			end
			stall = (idle_mode == 2'd2 && $urandom_range(0, 99) < 52) ||
				(idle_mode == 2'd3 && $urandom_range(0, 99) < 12);
			m_tready <= !stall;
		end
	end

	// ---------------------------------------------------------------
	// stimulus and end of run
	// ---------------------------------------------------------------

	initial begin
		scan.on_line2 = 1'b0;
		scan.cr_open  = 1'b0;
		scan.decided  = 1'b0;
		clear_line();

		// utf-8 token still open on the final byte, upper case
		add_text("coding=UTF-8");
		flush_frame();
		// cr lf ends line one, lf ends line two, trailing byte ignored
		frame_bytes = '{CHR_CR, CHR_LF, CHR_LF, 8'hFF};
		flush_frame();
		// single byte buffer, no verdict before the end
		frame_bytes = '{8'h00};
		flush_frame();
		// keyword without separator
		add_text("codingX");
		flush_frame();

		while (bytes_to_send.size() < 1974)
			build_random_frame();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// all words handed over
		@(negedge clk);
		while (bytes_to_send.size() != 0 || s_tvalid)
			@(negedge clk);
		while (verdicts_due.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule

@@ coding_cookie_detect.f @@
+incdir+src
src/ccd_pkg.sv
src/ccd_scan.sv
src/coding_cookie_detect.sv
tb/tb.sv
